/* sv/bounded_list_insert_remove_dump_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list block
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_REMOVE_DUMP_MACROS_SVH
`define BOUNDED_LIST_INSERT_REMOVE_DUMP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BLIRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BLIRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/blird_pkg.sv */
// ----------------------------------------------------------------------------
// blird_pkg
// Shared types, field widths and command codes of the bounded list block.
// ----------------------------------------------------------------------------
`default_nettype none

package blird_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 6;

    // Stream widths
    localparam int S_TDATA_W = 40;   // new_value, position, padding
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = VAL_W;
    localparam int M_TUSER_W = 2;

    // Bit places in the result tuser
    localparam int EMPTY_BIT = 0;
    localparam int DROP_BIT  = 1;

    // Command codes; the spare code acts as a removal
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd2;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [CMD_W-1:0]        t_cmd;

endpackage

`default_nettype wire

/* sv/blird_ram.sv */
// ----------------------------------------------------------------------------
// blird_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blird_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire blird_pkg::t_value     i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output blird_pkg::t_value          o_rdata
);
    import blird_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/bounded_list_insert_remove_dump.sv */
// ----------------------------------------------------------------------------
// bounded_list_insert_remove_dump
// Bounded ordered list of signed 32-bit values with insert, remove and dump.
// ----------------------------------------------------------------------------
// Each request inserts a value at the front or back, or removes the element at
// a position, and is answered by a dump of the whole list, front to back, with
// tlast on the final element (an empty list gives one result flagged empty).
// The list lives in a circular store addressed from a front pointer. Inserts
// and removal of the front element are done as the request is accepted;
// removal at position p moves the count-p-1 following entries down through
// the single read port of the store at one entry per cycle. The dump then
// reads one element per cycle, and a stalled result consumer stretches the
// dump. The next request is taken while the last result still waits in the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_insert_remove_dump #(
    parameter int CAPACITY = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Request stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [blird_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] new_value, [37:32] position
    input  wire logic [blird_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] command
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [blird_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] element_value
    output logic [blird_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] list_empty, [1] insert_dropped
    output logic                                m_tlast    // is_last
);
    import blird_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SHIFT      = 3'd1;
    localparam logic [2:0] ST_DUMP_START = 3'd2;
    localparam logic [2:0] ST_DUMP       = 3'd3;

    // Circular address of an offset from the front
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // Request fields
    t_cmd   req_cmd;
    t_value req_val;
    t_pos   req_pos;
    logic   req_acc;
    assign req_cmd = s_tuser;
    assign req_val = s_tdata[VAL_W-1:0];
    assign req_pos = s_tdata[VAL_W+POS_W-1:VAL_W];

    // Control registers
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic          r_drop,  n_drop;

    // Output register
    logic   r_m_valid, n_m_valid;
    t_value r_m_data;
    logic   r_m_last, r_m_empty, r_m_drop;
    logic   out_free, out_load, load_last, load_empty;
    t_value load_data;

    // Store ports
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_value        mem_wdata, mem_rdata;

    blird_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign req_acc  = s_tvalid && s_tready;
    assign out_free = !r_m_valid || m_tready;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_drop     = r_drop;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = req_val;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        out_load   = 1'b0;
        load_last  = 1'b0;
        load_empty = 1'b0;
        load_data  = mem_rdata;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_drop  = 1'b0;
                    n_state = ST_DUMP_START;
                    if (req_cmd == CMD_PUSH_FRONT || req_cmd == CMD_PUSH_BACK) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_drop = 1'b1;
                        end else if (req_cmd == CMD_PUSH_FRONT) begin
                            n_front   = (r_front == '0) ? AW'(CAPACITY - 1)
                                                        : r_front - AW'(1);
                            mem_we    = 1'b1;
                            mem_waddr = n_front;
                            n_count   = r_count + CW'(1);
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = slot(r_front, r_count);
                            n_count   = r_count + CW'(1);
                        end
                    end else if (CMPW'(req_pos) < CMPW'(r_count)) begin
                        if (req_pos == '0) begin
                            // Front removal just advances the pointer
                            n_front = slot(r_front, CW'(1));
                            n_count = r_count - CW'(1);
                        end else if (CMPW'(req_pos) + CMPW'(1) < CMPW'(r_count)) begin
                            // Fetch the entry after the hole, then shift down
                            mem_re    = 1'b1;
                            mem_raddr = slot(r_front, CW'(req_pos) + CW'(1));
                            n_idx     = CW'(req_pos);
                            n_state   = ST_SHIFT;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            ST_SHIFT: begin
                // Write the fetched entry one place down, fetch the next one
                mem_we    = 1'b1;
                mem_waddr = slot(r_front, r_idx);
                mem_wdata = mem_rdata;
                if (CMPW'(r_idx) + CMPW'(2) < CMPW'(r_count)) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, r_idx + CW'(2));
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DUMP_START;
                end
            end
            ST_DUMP_START: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        load_last  = 1'b1;
                        load_empty = 1'b1;
                        load_data  = '0;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_front;
                    n_idx     = '0;
                    n_state   = ST_DUMP;
                end
            end
            ST_DUMP: begin
                // One element per cycle while the output register drains
                if (out_free) begin
                    out_load  = 1'b1;
                    load_last = (CMPW'(r_idx) + CMPW'(1) == CMPW'(r_count));
                    if (load_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = slot(r_front, r_idx + CW'(1));
                        n_idx     = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb begin
        n_m_valid = r_m_valid && !m_tready;
        if (out_load) begin
            n_m_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_drop    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_drop    <= n_drop;
            r_m_valid <= n_m_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data  <= load_data;
            r_m_last  <= load_last;
            r_m_empty <= load_empty;
            r_m_drop  <= r_drop;
        end
    end

    assign m_tvalid            = r_m_valid;
    assign m_tdata             = r_m_data;
    assign m_tlast             = r_m_last;
    assign m_tuser[EMPTY_BIT]  = r_m_empty;
    assign m_tuser[DROP_BIT]   = r_m_drop;

endmodule

`default_nettype wire

/* sv/blird_checker.sv */
// ----------------------------------------------------------------------------
// blird_checker
// Port-level checks on the result stream of the bounded list block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_list_insert_remove_dump_macros.svh"

module blird_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [blird_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [blird_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                            m_tlast
);
    import blird_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic          out_acc;
    logic [CW-1:0] r_cnt;
    logic          r_mid;
    logic          r_drop;

    assign out_acc = m_tvalid && m_tready;

    // Track position and drop flag within the current dump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mid  <= 1'b0;
            r_drop <= 1'b0;
        end else if (out_acc) begin
            if (m_tlast) begin
                r_cnt <= '0;
                r_mid <= 1'b0;
            end else begin
                r_cnt  <= r_cnt + CW'(1);
                r_mid  <= 1'b1;
                r_drop <= m_tuser[DROP_BIT];
            end
        end
    end

    // An empty-list result is a one-result dump and never a dropped insert
    `BLIRD_ASSERT_IMP(a_empty_single, i_clk, i_rst_n, m_tvalid && m_tuser[EMPTY_BIT], m_tlast && !m_tuser[DROP_BIT], "empty result not last or flagged dropped")

    // A dump never runs past the capacity
    `BLIRD_ASSERT_IMP(a_dump_bounded, i_clk, i_rst_n, out_acc, r_cnt < CW'(CAPACITY), "dump longer than capacity")

    // The drop flag is the same on every result of one dump
    `BLIRD_ASSERT_IMP(a_drop_steady, i_clk, i_rst_n, out_acc && r_mid, m_tuser[DROP_BIT] == r_drop, "drop flag changed within a dump")

    // A dropped insert means a full list, so the dump has capacity results
    `BLIRD_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, out_acc && m_tuser[DROP_BIT] && m_tlast, r_cnt == CW'(CAPACITY - 1), "dropped insert on a list that was not full")

    // A stalled result holds
    `BLIRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind bounded_list_insert_remove_dump blird_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire
